// ----- hw/rtl/drsc_pkg.sv -----
// ----------------------------------------------------------------------------
// drsc_pkg
// Shared types and constants for the dirty row span coalescer.
// ----------------------------------------------------------------------------
package drsc_pkg;

  localparam int ROWS = 512;
  localparam int COLS = 512;
  localparam int RW   = 9;    // row index width
  localparam int CW   = 9;    // column index width

  localparam logic [1:0] OP_MARK  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_SPAN  = 2'd2;
  localparam logic [1:0] OP_ALL   = 2'd3;

  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_ROWS   = 2'd1;
  localparam logic [1:0] REG_COST   = 2'd2;

  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  // row entry: dirty bit, first and last column
  typedef struct packed {
    logic          dirty;
    logic [CW-1:0] first;
    logic [CW-1:0] last;
  } row_ent_t;

  localparam int EW = 1 + 2 * CW;

endpackage

// ----- hw/rtl/drsc_ram.sv -----
// ----------------------------------------------------------------------------
// drsc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module drsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/dirty_row_span_coalescer.sv -----
// ----------------------------------------------------------------------------
// dirty_row_span_coalescer
// Per-row dirty tracking with rectangle marking, rolling resync and span scan.
// ----------------------------------------------------------------------------
// Usage:
//   in_tdata carries one command transaction (operation and rectangle). Each
//   command yields exactly one result transaction on out_*. cfg_* writes the
//   resync period, rows per resync and span cost; the user must do this only
//   while the block is idle, which the block itself does not enforce.
// Timing:
//   Row state lives in one 512 x 19 RAM with registered reads. Marks walk
//   rows with read/modify/write states, span scans with read/check states;
//   an empty mark walks none. Begin frame first works out the slot remainder,
//   then marks up to rows_per_resync rows. Done adds a clearing pass over all
//   rows, as does mark all. Worst case is a scan over a clean screen.
// Reset:
//   Registers take their default values; a clearing pass over every row then
//   sets each row dirty at full width, with in_tready low until it ends.
// Stall:
//   The result waits in an output register; a new command is taken only after
//   the previous result has left.
// ----------------------------------------------------------------------------
module dirty_row_span_coalescer
  import drsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] operation, [13:2] left_x, [25:14] top_y, [37:26] right_x,
  // [49:38] bottom_y, [55:50] zero
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] span_valid, [9:1] span_x_first, [18:10] span_y_first,
  // [27:19] span_x_last, [36:28] span_y_last, [37] frame_done,
  // [47:38] resync_count
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MOD   = 8'b00000010,
    S_MRD   = 8'b00000100,
    S_MWR   = 8'b00001000,
    S_SRD   = 8'b00010000,
    S_SCHK  = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_CLR   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] period_r;
  logic [9:0]  rows_r;
  logic [15:0] cost_r;
  logic [15:0] slot_r;
  logic [RW:0] cursor_r;

  // clearing pass: dirty value to write, and whether it is the one after reset
  logic        clr_dirty_r;
  logic        init_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd60;
      rows_r   <= 10'd16;
      cost_r   <= 16'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PERIOD: period_r <= cfg_data;
        REG_ROWS:   rows_r   <= cfg_data[9:0];
        REG_COST:   cost_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // RAM
  logic           we;
  logic [RW-1:0]  waddr, raddr;
  row_ent_t       wdata, rd;

  drsc_ram #(.WIDTH(EW), .DEPTH(ROWS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  // command and working registers
  logic [1:0]    op_r;
  logic [CW-1:0] x0_r, x1_r;
  logic [RW:0]   y_r, yend_r;      // current row, last row of a mark
  logic [RW-1:0] y0_r;
  logic          have_r;           // span has its first row
  logic [CW-1:0] sx0_r, sx1_r;
  logic [9:0]    rcnt_r;
  logic [15:0]   smod_r;           // slot remainder
  logic [15:0]   dvd_r;            // slot bits still to shift in
  logic [4:0]    div_cnt_r;        // bit 4 set once the remainder is ready
  logic [47:0]   out_r;
  logic          out_v_r;

  assign in_tready  = (state_r == S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  // input decode and clamp
  logic [1:0]         i_op;
  logic signed [11:0] i_l, i_t, i_r, i_b;
  assign i_op = in_tdata[1:0];
  assign i_l  = in_tdata[13:2];
  assign i_t  = in_tdata[25:14];
  assign i_r  = in_tdata[37:26];
  assign i_b  = in_tdata[49:38];

  logic [CW-1:0] c_l, c_r;
  logic [RW-1:0] c_t, c_b;
  logic          c_empty;
  always_comb begin
    c_l = i_l[11] ? '0 : (i_l > 12'sd511 ? LAST_COL : i_l[CW-1:0]);
    c_r = i_r > 12'sd511 ? LAST_COL : i_r[CW-1:0];
    c_t = i_t[11] ? '0 : (i_t > 12'sd511 ? LAST_ROW : i_t[RW-1:0]);
    c_b = i_b > 12'sd511 ? LAST_ROW : i_b[RW-1:0];
    c_empty = i_r[11] || i_b[11] || (i_l > i_r && !i_l[11]) ||
              (i_t > i_b && !i_t[11]) || (i_l > 12'sd511) || (i_t > 12'sd511);
  end

  // merge arithmetic for the span check
  logic [CW-1:0] ux0, ux1;
  logic [CW:0]   own;
  logic [31:0]   grow, extra;
  always_comb begin
    ux0  = (rd.first < sx0_r) ? rd.first : sx0_r;
    ux1  = (rd.last > sx1_r) ? rd.last : sx1_r;
    own  = (rd.last >= rd.first) ? {1'b0, rd.last - rd.first} : '0;
    grow = 32'(({1'b0, ux1 - ux0} - {1'b0, sx1_r - sx0_r}) * 2);
    extra = 32'(y_r - {1'b0, y0_r}) * grow +
            32'(({1'b0, ux1 - ux0} - own) * 2);
  end

  // restoring remainder step: slot modulo period, one bit per cycle
  logic [16:0] rem_sh;
  logic [15:0] rem_step;
  assign rem_sh   = {smod_r, dvd_r[15]};
  assign rem_step = (rem_sh >= {1'b0, period_r}) ? 16'(rem_sh - {1'b0, period_r})
                                                 : rem_sh[15:0];

  // resync slice start: slot times rows (16 x 10)
  logic [25:0] r0;
  logic [26:0] r1;
  assign r0 = smod_r * rows_r;
  assign r1 = 27'(r0) + 27'(rows_r) - 27'd1;

  logic [15:0] slot_nxt;
  assign slot_nxt = smod_r + 16'd1;

  always_comb begin
    state_nxt = state_r;
    we = 1'b0;
    waddr = y_r[RW-1:0];
    raddr = y_r[RW-1:0];
    wdata = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          case (i_op)
            OP_MARK:  state_nxt = c_empty ? S_OUT : S_MRD;
            OP_FRAME: state_nxt = (period_r == 16'd0) ? S_OUT : S_MOD;
            OP_SPAN:  state_nxt = S_SRD;
            OP_ALL:   state_nxt = S_CLR;
            default:  state_nxt = S_OUT;
          endcase
          raddr = (i_op == OP_SPAN) ? cursor_r[RW-1:0] : c_t;
        end
      end
      S_MOD: begin
        if (div_cnt_r[4]) begin
          if (rows_r != 10'd0 && r0 < 26'(ROWS)) begin
            state_nxt = S_MRD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_MRD: state_nxt = S_MWR;
      S_MWR: begin
        we = 1'b1;
        wdata.dirty = 1'b1;
        if (rd.dirty) begin
          wdata.first = (x0_r < rd.first) ? x0_r : rd.first;
          wdata.last  = (x1_r > rd.last) ? x1_r : rd.last;
        end else begin
          wdata.first = x0_r;
          wdata.last  = x1_r;
        end
        raddr = 9'(y_r + 1'b1);
        state_nxt = (y_r == yend_r) ? S_OUT : S_MRD;
      end
      S_SRD: begin
        if (y_r == (RW+1)'(ROWS)) state_nxt = have_r ? S_OUT : S_CLR;
        else state_nxt = S_SCHK;
      end
      S_SCHK: begin
        raddr = 9'(y_r + 1'b1);
        if (!have_r) begin
          state_nxt = S_SRD;
        end else if (!rd.dirty || extra > 32'(cost_r)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_CLR: begin
        we = 1'b1;
        wdata.dirty = clr_dirty_r;
        wdata.first = '0;
        wdata.last  = LAST_COL;
        if (y_r == (RW+1)'(ROWS - 1)) state_nxt = init_r ? S_IDLE : S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      out_v_r <= 1'b0;
      clr_dirty_r <= 1'b1;
      init_r <= 1'b1;
      y_r <= '0;
      slot_r <= '0;
      cursor_r <= '0;
      have_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r <= i_op;
            rcnt_r <= '0;
            have_r <= 1'b0;
            x0_r <= c_l;
            x1_r <= c_r;
            yend_r <= {1'b0, c_b};
            smod_r <= '0;
            dvd_r <= slot_r;
            div_cnt_r <= '0;
            if (i_op == OP_SPAN) y_r <= cursor_r;
            else if (i_op == OP_ALL) y_r <= '0;
            else y_r <= {1'b0, c_t};
            if (i_op == OP_FRAME) cursor_r <= '0;
            if (i_op == OP_ALL) clr_dirty_r <= 1'b1;
          end
        end
        S_MOD: begin
          if (!div_cnt_r[4]) begin
            smod_r <= rem_step;
            dvd_r <= {dvd_r[14:0], 1'b0};
            div_cnt_r <= div_cnt_r + 5'd1;
          end else begin
            slot_r <= (slot_nxt == period_r) ? 16'd0 : slot_nxt;
            x0_r <= '0;
            x1_r <= LAST_COL;
            if (rows_r != 10'd0 && r0 < 26'(ROWS)) begin
              y_r <= r0[RW:0];
              yend_r <= (r1 > 27'(ROWS - 1)) ? (RW+1)'(ROWS - 1) : r1[RW:0];
              rcnt_r <= (r1 > 27'(ROWS - 1)) ? 10'(ROWS - r0) : rows_r;
            end
          end
        end
        S_MWR: y_r <= y_r + 1'b1;
        S_SRD: begin
          // scan found no dirty row from the cursor on: clear every row before reporting done
          if (y_r == (RW+1)'(ROWS) && !have_r) begin
            y_r <= '0;
            clr_dirty_r <= 1'b0;
          end
        end
        S_SCHK: begin
          if (!have_r) begin
            if (rd.dirty) begin
              have_r <= 1'b1;
              y0_r <= y_r[RW-1:0];
              sx0_r <= rd.first;
              sx1_r <= rd.last;
            end
            y_r <= y_r + 1'b1;
          end else if (rd.dirty && extra <= 32'(cost_r)) begin
            sx0_r <= ux0;
            sx1_r <= ux1;
            y_r <= y_r + 1'b1;
          end
        end
        S_CLR: begin
          y_r <= y_r + 1'b1;
          if (y_r == (RW+1)'(ROWS - 1)) init_r <= 1'b0;
        end
        S_OUT: begin
          out_v_r <= 1'b1;
          if (op_r == OP_SPAN && have_r) begin
            cursor_r <= y_r;
            out_r <= {10'd0, 1'b0, 9'(y_r - 1'b1), sx1_r, y0_r, sx0_r, 1'b1};
          end else if (op_r == OP_SPAN) begin
            cursor_r <= '0;
            out_r <= {10'd0, 1'b1, 37'd0};
          end else begin
            out_r <= {rcnt_r, 38'd0};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/drsc_checker.sv -----
// ----------------------------------------------------------------------------
// drsc_port_checker
// Port-level checks for the dirty row span coalescer.
// ----------------------------------------------------------------------------
module drsc_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // a new command is never taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("command taken with result pending");

  // span and done are exclusive
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[37])) else $error("span and done");

  // result never appears in the cycle right after a command
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid) else $error("result too early");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");

endmodule

bind dirty_row_span_coalescer drsc_port_checker u_drsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
